### sv/ets_pkg.sv
// Shared types and character/kind constants for the expression token scanner.
`default_nettype none
package ets_pkg;

	typedef enum logic [3:0] {
		KIND_END    = 4'd0,
		KIND_DEC    = 4'd1,
		KIND_BIN    = 4'd2,
		KIND_HEX    = 4'd3,
		KIND_PLUS   = 4'd4,
		KIND_MINUS  = 4'd5,
		KIND_MULT   = 4'd6,
		KIND_DIV    = 4'd7,
		KIND_LPAREN = 4'd8,
		KIND_RPAREN = 4'd9,
		KIND_ERROR  = 4'd10
	} kind_t;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	// One classified item: a result, optionally preceded by an error result
	// with no text (the end marker after a lone leading zero).
	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       has;
		logic       start;
		logic       pair;
	} cmd_t;

endpackage
`default_nettype wire

### sv/ets_front.sv
// Front end: accepts characters, tracks the scan mode and classifies each beat.
`default_nettype none
module ets_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         accept,
	input  wire logic [7:0]   char_in,
	input  wire logic         end_of_text,
	output ets_pkg::cmd_t     cmd,
	output logic              cmd_valid
);
	import ets_pkg::*;

	typedef enum logic [4:0] {
		MODE_IDLE = 5'b00001,
		MODE_DEC  = 5'b00010,
		MODE_ZERO = 5'b00100,
		MODE_BIN  = 5'b01000,
		MODE_HEX  = 5'b10000
	} mode_t;

	mode_t mode_q, mode_nxt;
	logic  err_q, err_nxt;
	logic  emit;
	logic  is_digit, is_hex;

	always_comb begin
		is_digit = (char_in inside {[CH_ZERO:CH_NINE]});
		is_hex   = is_digit || (char_in inside {[CH_LOW_A:CH_LOW_F]});
	end

	// Classify the current character against the scan mode.
	always_comb begin
		emit      = 1'b0;
		cmd.kind  = KIND_ERROR;
		cmd.ch    = char_in;
		cmd.has   = 1'b1;
		cmd.start = 1'b1;
		cmd.pair  = 1'b0;
		mode_nxt  = mode_q;
		err_nxt   = err_q;
		if (end_of_text) begin
			emit     = 1'b1;
			cmd.kind = KIND_END;
			cmd.ch   = 8'd0;
			cmd.has  = 1'b0;
			cmd.pair = !err_q && (mode_q == MODE_ZERO);
			err_nxt  = 1'b0;
			mode_nxt = MODE_IDLE;
		end else if (err_q) begin
			mode_nxt = MODE_IDLE;
		end else if (mode_q == MODE_DEC && is_digit) begin
			emit      = 1'b1;
			cmd.kind  = KIND_DEC;
			cmd.start = 1'b0;
		end else if (mode_q == MODE_BIN && (char_in == CH_ZERO || char_in == CH_ONE)) begin
			emit      = 1'b1;
			cmd.kind  = KIND_BIN;
			cmd.start = 1'b0;
		end else if (mode_q == MODE_HEX && is_hex) begin
			emit      = 1'b1;
			cmd.kind  = KIND_HEX;
			cmd.start = 1'b0;
		end else if (mode_q == MODE_ZERO) begin
			emit = 1'b1;
			if (char_in == CH_LOW_B) begin
				mode_nxt = MODE_BIN;
				cmd.kind = KIND_BIN;
				cmd.ch   = 8'd0;
				cmd.has  = 1'b0;
			end else if (char_in == CH_LOW_X) begin
				mode_nxt = MODE_HEX;
				cmd.kind = KIND_HEX;
				cmd.ch   = 8'd0;
				cmd.has  = 1'b0;
			end else begin
				err_nxt  = 1'b1;
				mode_nxt = MODE_IDLE;
			end
		end else begin
			// Start of a new token.
			mode_nxt = MODE_IDLE;
			emit     = 1'b1;
			case (char_in) inside
				CH_SPACE, CH_TAB: emit = 1'b0;
				CH_ZERO: begin
					emit     = 1'b0;
					mode_nxt = MODE_ZERO;
				end
				[CH_ONE:CH_NINE]: begin
					cmd.kind = KIND_DEC;
					mode_nxt = MODE_DEC;
				end
				CH_PLUS:   cmd.kind = KIND_PLUS;
				CH_MINUS:  cmd.kind = KIND_MINUS;
				CH_STAR:   cmd.kind = KIND_MULT;
				CH_SLASH:  cmd.kind = KIND_DIV;
				CH_LPAREN: cmd.kind = KIND_LPAREN;
				CH_RPAREN: cmd.kind = KIND_RPAREN;
				default:   err_nxt = 1'b1;
			endcase
		end
	end

	assign cmd_valid = accept && emit;

	// Advance the scan state on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			err_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_nxt;
			err_q  <= err_nxt;
		end
	end

endmodule
`default_nettype wire

### sv/ets_queue.sv
// Short command queue between the front end and the result stage.
`default_nettype none
module ets_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire ets_pkg::cmd_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output ets_pkg::cmd_t      rd_data,
	output logic               empty
);
	import ets_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store an incoming command.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and track occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/ets_back.sv
// Result stage: expands queued commands into one or two result beats.
`default_nettype none
module ets_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ets_pkg::cmd_t head,
	input  wire logic          head_empty,
	output logic               head_pop,
	input  wire logic          pop,
	output logic               empty,
	output logic [3:0]         token_kind,
	output logic [7:0]         text_char,
	output logic               has_char,
	output logic               token_start,
	output logic               last_result
);
	import ets_pkg::*;

	logic phase_q;
	logic lead_err;
	logic take;

	// Emit the leading error beat first when the command carries one.
	assign lead_err    = head.pair && !phase_q;
	assign empty       = head_empty;
	assign take        = pop && !head_empty;
	assign head_pop    = take && !lead_err;
	assign token_kind  = lead_err ? KIND_ERROR : head.kind;
	assign text_char   = lead_err ? 8'd0 : head.ch;
	assign has_char    = lead_err ? 1'b0 : head.has;
	assign token_start = lead_err ? 1'b1 : head.start;
	assign last_result = !lead_err;

	// Track which beat of a paired command is on the ports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (take) begin
			phase_q <= lead_err;
		end
	end

endmodule
`default_nettype wire

### sv/expression_token_scanner.sv
// Top level of the expression token scanner.
// Takes one character (or end marker) per clock and can accept a new one every
// cycle while full is low; classification and the scan-mode update happen in the
// cycle the beat is accepted, so there is no feedback stall. Each accepted beat
// produces zero, one or two result beats, delivered one per cycle while pop is
// held, from a QUEUE_DEPTH-entry command queue; full rises only when every entry
// of that queue is occupied, which happens when the result side is slow to pop.
// The end marker after a lone leading zero holds its queue entry until both of its
// beats (error beat, then end beat) are popped, behind any older queued results.
`default_nettype none
module expression_token_scanner #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_in,
	input  wire logic       end_of_text,
	output logic            empty,
	input  wire logic       pop,
	output logic [3:0]      token_kind,
	output logic [7:0]      text_char,
	output logic            has_char,
	output logic            token_start,
	output logic            last_result
);
	import ets_pkg::*;

	cmd_t cmd, head;
	logic cmd_valid, accept, head_empty, head_pop;

	assign accept = push && !full;

	ets_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_in     (char_in),
		.end_of_text (end_of_text),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid)
	);

	ets_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd),
		.full    (full),
		.rd_en   (head_pop),
		.rd_data (head),
		.empty   (head_empty)
	);

	ets_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_empty  (head_empty),
		.head_pop    (head_pop),
		.pop         (pop),
		.empty       (empty),
		.token_kind  (token_kind),
		.text_char   (text_char),
		.has_char    (has_char),
		.token_start (token_start),
		.last_result (last_result)
	);

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the expression token scanner: predictor, stimulus and result checks.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ets_pkg::*;

	localparam int HOLD_CYCLES   = 120;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BEATS  = 1950;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_DEC,
		SCAN_ZERO,
		SCAN_BIN,
		SCAN_HEX
	} scan_state_t;

	typedef enum logic [1:0] {
		POP_ALWAYS,
		POP_COIN,
		POP_SPARSE,
		POP_WAVES
	} pop_pattern_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] ch;
		logic       has;
		logic       start;
		logic       last;
	} token_beat_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       push        = 1'b0;
	logic [7:0] char_in     = 8'h00;
	logic       end_of_text = 1'b0;
	logic       pop         = 1'b0;
	logic       full;
	logic       empty;
	logic [3:0] token_kind;
	logic [7:0] text_char;
	logic       has_char;
	logic       token_start;
	logic       last_result;

	// Scanner state as the predictor sees it
	scan_state_t scan_state = SCAN_IDLE;
	logic        err_hold   = 1'b0;

	token_beat_t  expected_tokens[$];
	int unsigned  mismatch_count = 0;
	int unsigned  beats_sent     = 0;
	int unsigned  burst_left     = 0;
	logic         hold_results   = 1'b0;
	logic         draining       = 1'b0;
	int unsigned  hold_left      = 0;
	pop_pattern_t pop_pattern    = POP_ALWAYS;
	logic [7:0]   pattern_cycle  = 8'd0;

	logic [7:0] operator_chars [6] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN};

	expression_token_scanner i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_in     (char_in),
		.end_of_text (end_of_text),
		.empty       (empty),
		.pop         (pop),
		.token_kind  (token_kind),
		.text_char   (text_char),
		.has_char    (has_char),
		.token_start (token_start),
		.last_result (last_result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic is_dec_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_hex_digit(input logic [7:0] c);
		return is_dec_digit(c) || (c >= CH_LOW_A && c <= CH_LOW_F);
	endfunction

	function automatic token_beat_t token_beat(input kind_t kind, input logic [7:0] ch,
			input logic has, input logic start);
		token_beat_t t;
		t.kind  = kind;
		t.ch    = ch;
		t.has   = has;
		t.start = start;
		t.last  = 1'b0;
		return t;
	endfunction

	// Advance the scanner state by one accepted beat and queue the tokens it yields
	task automatic predict_tokens(input logic [7:0] c, input logic eot);
		token_beat_t outs[$];
		kind_t       op_kind;
		if (eot) begin
			if (!err_hold && scan_state == SCAN_ZERO)
				outs.push_back(token_beat(KIND_ERROR, 8'h00, 1'b0, 1'b1));
			outs.push_back(token_beat(KIND_END, 8'h00, 1'b0, 1'b1));
			err_hold   = 1'b0;
			scan_state = SCAN_IDLE;
		end else if (err_hold) begin
			scan_state = SCAN_IDLE;
		end else if (scan_state == SCAN_DEC && is_dec_digit(c)) begin
			outs.push_back(token_beat(KIND_DEC, c, 1'b1, 1'b0));
		end else if (scan_state == SCAN_BIN && (c == CH_ZERO || c == CH_ONE)) begin
			outs.push_back(token_beat(KIND_BIN, c, 1'b1, 1'b0));
		end else if (scan_state == SCAN_HEX && is_hex_digit(c)) begin
			outs.push_back(token_beat(KIND_HEX, c, 1'b1, 1'b0));
		end else if (scan_state == SCAN_ZERO) begin
			// Prefix letter opens a based literal; anything else after a leading zero fails
			if (c == CH_LOW_B) begin
				scan_state = SCAN_BIN;
				outs.push_back(token_beat(KIND_BIN, 8'h00, 1'b0, 1'b1));
			end else if (c == CH_LOW_X) begin
				scan_state = SCAN_HEX;
				outs.push_back(token_beat(KIND_HEX, 8'h00, 1'b0, 1'b1));
			end else begin
				err_hold   = 1'b1;
				scan_state = SCAN_IDLE;
				outs.push_back(token_beat(KIND_ERROR, c, 1'b1, 1'b1));
			end
		end else begin
			// Scan the character as the start of a new token
			scan_state = SCAN_IDLE;
			if (c == CH_SPACE || c == CH_TAB) begin
			end else if (c == CH_ZERO) begin
				scan_state = SCAN_ZERO;
			end else if (is_dec_digit(c)) begin
				scan_state = SCAN_DEC;
				outs.push_back(token_beat(KIND_DEC, c, 1'b1, 1'b1));
			end else begin
				case (c)
					CH_PLUS:   op_kind = KIND_PLUS;
					CH_MINUS:  op_kind = KIND_MINUS;
					CH_STAR:   op_kind = KIND_MULT;
					CH_SLASH:  op_kind = KIND_DIV;
					CH_LPAREN: op_kind = KIND_LPAREN;
					CH_RPAREN: op_kind = KIND_RPAREN;
					default:   op_kind = KIND_ERROR;
				endcase
				if (op_kind == KIND_ERROR)
					err_hold = 1'b1;
				outs.push_back(token_beat(op_kind, c, 1'b1, 1'b1));
			end
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[i])
			expected_tokens.push_back(outs[i]);
	endtask

	// Offer one beat, idling between bursts, and hold it until accepted
	task automatic send_beat(input logic [7:0] c, input logic eot);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push        <= 1'b1;
		char_in     <= c;
		end_of_text <= eot;
		do @(posedge clk); while (full);
		predict_tokens(c, eot);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	// Stop offering and wait until every queued token has come out
	task automatic drain_results();
		push     <= 1'b0;
		draining  = 1'b1;
		while (expected_tokens.size() != 0 || hold_results)
			@(posedge clk);
		draining = 1'b0;
	endtask

	// One random expression: mostly well-formed tokens, some noise, closed by an end marker
	task automatic gen_expression();
		int unsigned n_parts;
		int unsigned len;
		int unsigned d;
		n_parts = $urandom_range(1, 10);
		for (int p = 0; p < n_parts; p++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					send_beat(CH_ONE + 8'($urandom_range(0, 8)), 1'b0);
					len = $urandom_range(0, 5);
					repeat (len) send_beat(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
				end
				2: begin
					send_beat(CH_ZERO, 1'b0);
					send_beat(CH_LOW_B, 1'b0);
					len = $urandom_range(0, 6);
					repeat (len) send_beat(CH_ZERO + 8'($urandom_range(0, 1)), 1'b0);
				end
				3: begin
					send_beat(CH_ZERO, 1'b0);
					send_beat(CH_LOW_X, 1'b0);
					len = $urandom_range(0, 6);
					repeat (len) begin
						d = $urandom_range(0, 15);
						send_beat(d < 10 ? CH_ZERO + 8'(d) : CH_LOW_A + 8'(d - 10), 1'b0);
					end
				end
				4, 5, 6: send_beat(operator_chars[$urandom_range(0, 5)], 1'b0);
				7: begin
					len = $urandom_range(1, 3);
					repeat (len) send_beat($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
				end
				8: send_beat(CH_SPACE, 1'b0);
				default: begin
					// Inject noise: stray bytes, a bad leading zero, junk after an error, or a plain operator
					case ($urandom_range(0, 3))
						0: send_beat(8'($urandom), 1'b0);
						1: begin
							send_beat(CH_ZERO, 1'b0);
							send_beat(8'($urandom), 1'b0);
						end
						2: begin
							send_beat(8'($urandom_range(128, 255)), 1'b0);
							len = $urandom_range(1, 4);
							repeat (len) send_beat(8'($urandom), 1'b0);
						end
						default: send_beat(operator_chars[$urandom_range(0, 5)], 1'b0);
					endcase
				end
			endcase
		end
		// Sometimes end the text right after a lone zero
		if ($urandom_range(0, 9) == 0)
			send_beat(CH_ZERO, 1'b0);
		send_beat(8'($urandom), 1'b1);
	endtask

	task automatic test_directed_tokens();
		send_text("(90-0b1)*0xaf/ +\t");
		send_beat(8'h00, 1'b1);
	endtask

	task automatic test_error_cases();
		// Leading zero followed by a digit, then a character swallowed by the error
		send_text("07+");
		send_beat(8'h00, 1'b1);
		// Lone zero at the end of text
		send_text("0");
		send_beat(8'hFF, 1'b1);
		// Bytes that cannot start a token
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h00, 1'b1);
	endtask

	task automatic test_random_expressions(input int unsigned n_beats);
		int unsigned stop_at;
		stop_at = beats_sent + n_beats;
		while (beats_sent < stop_at)
			gen_expression();
	endtask

	// Hold off the result side while beats keep coming, so the input stalls
	task automatic test_result_holdoff();
		hold_results = 1'b1;
		repeat (3) gen_expression();
	endtask

	// Result side: pop on a changing pattern, with long hold-offs on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_results && hold_left == 0)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0)
					hold_results = 1'b0;
				pop <= 1'b0;
			end else if (draining) begin
				pop <= 1'b1;
			end else begin
				if (pattern_cycle == 8'd0)
					pop_pattern = pop_pattern_t'($urandom_range(0, 3));
				pattern_cycle++;
				case (pop_pattern)
					POP_ALWAYS: pop <= 1'b1;
					POP_COIN:   pop <= 1'($urandom_range(0, 1));
					POP_SPARSE: pop <= (pattern_cycle[1:0] == 2'd0);
					default:    pop <= (pattern_cycle[5:4] != 2'd0);
				endcase
			end
		end
	end

	// Compare each popped beat with the oldest predicted token
	always @(posedge clk) begin
		token_beat_t want;
		if (arst_n && pop && !empty) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected result beat: token_kind %0d text_char %0h",
					token_kind, text_char);
				mismatch_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (token_kind !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
					mismatch_count++;
				end
				if (text_char !== want.ch) begin
					$error("text_char: expected %0h, got %0h", want.ch, text_char);
					mismatch_count++;
				end
				if (has_char !== want.has) begin
					$error("has_char: expected %0b, got %0b", want.has, has_char);
					mismatch_count++;
				end
				if (token_start !== want.start) begin
					$error("token_start: expected %0b, got %0b", want.start, token_start);
					mismatch_count++;
				end
				if (last_result !== want.last) begin
					$error("last_result: expected %0b, got %0b", want.last, last_result);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus sequence
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_tokens();
		drain_results();
		test_error_cases();
		drain_results();
		test_result_holdoff();
		drain_results();
		test_random_expressions(RANDOM_BEATS);
		drain_results();
		test_result_holdoff();
		drain_results();
		// Keep popping a little longer to catch stray beats
		draining = 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_tokens.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
